>>> hdl/msgd_pkg.sv
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared types and constants of the mask set group dedup block: field widths,
// command codes, sequencer states, lane control and result bundles.
// ----------------------------------------------------------------------------
package msgd_pkg;

   // fixed field widths of the request and response channels
   localparam int CMD_W  = 2;
   localparam int ID_W   = 10;
   localparam int GIDX_W = 6;
   localparam int GTOT_W = 7;
   localparam int BTOT_W = 5;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_MASK_ID  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NO_MASKS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_LEN,
      ST_SCAN,
      ST_CHECK,
      ST_COPY,
      ST_EMIT
   } state_type;

   // control from the sequencer to the current-list lanes
   typedef struct packed {
      logic clear;       // drop the collected list
      logic append;      // take one id from the request
      logic scan_start;  // clear the found bits before a group scan
      logic probe;       // compare one stored id against all lanes
   } lane_ctl_type;

   // result flags and index, totals are added when the response is loaded
   typedef struct packed {
      logic              is_masked;
      logic [GIDX_W-1:0] group_index;
      logic              new_group;
      logic              table_full;
      logic              list_too_long;
   } res_type;

endpackage

>>> hdl/msgd_req_if.sv
// ----------------------------------------------------------------------------
// msgd_req_if
// Request channel: one mask id or command per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface msgd_req_if;
   logic                       valid;
   logic                       ready;
   logic [msgd_pkg::CMD_W-1:0] command;
   logic [msgd_pkg::ID_W-1:0]  mask_id;
   logic                       last;

   modport source (output valid, command, mask_id, last, input ready);
   modport sink   (input valid, command, mask_id, last, output ready);
endinterface

>>> hdl/msgd_rsp_if.sv
// ----------------------------------------------------------------------------
// msgd_rsp_if
// Response channel: clip group assignment of one drawable, valid/ready.
// ----------------------------------------------------------------------------
interface msgd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        is_masked;
   logic [msgd_pkg::GIDX_W-1:0] group_index;
   logic                        new_group;
   logic                        table_full;
   logic                        list_too_long;
   logic [msgd_pkg::GTOT_W-1:0] group_total;
   logic [msgd_pkg::BTOT_W-1:0] buffer_total;

   modport source (output valid, is_masked, group_index, new_group, table_full,
                   list_too_long, group_total, buffer_total, input ready);
   modport sink   (input valid, is_masked, group_index, new_group, table_full,
                   list_too_long, group_total, buffer_total, output ready);
endinterface

>>> hdl/msgd_ram.sv
// ----------------------------------------------------------------------------
// msgd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module msgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/msgd_lanes.sv
// ----------------------------------------------------------------------------
// msgd_lanes
// Current mask list held in lanes, one id per lane, with a found bit per lane.
// A probed stored id is compared against all lanes at once.
// ----------------------------------------------------------------------------
module msgd_lanes #(
   parameter int MAX_MASKS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  msgd_pkg::lane_ctl_type                        ctl,
   input  logic [msgd_pkg::ID_W-1:0]                     app_id,
   input  logic [msgd_pkg::ID_W-1:0]                     probe_id,
   input  logic [(MAX_MASKS > 1 ? $clog2(MAX_MASKS) : 1)-1:0] rd_idx,
   output logic [$clog2(MAX_MASKS + 1)-1:0]              cur_len,
   output logic                                          cur_over,
   output logic                                          all_found,
   output logic [msgd_pkg::ID_W-1:0]                     rd_id
);

   localparam int LW = $clog2(MAX_MASKS + 1);

   logic [msgd_pkg::ID_W-1:0] lane_ff [MAX_MASKS];
   logic [MAX_MASKS-1:0]      found_ff, found_in;
   logic [LW-1:0]             len_ff, len_in;
   logic                      over_ff, over_in;
   logic [MAX_MASKS-1:0]      lane_ok;

   // length and overflow flag
   always_comb begin
      len_in  = len_ff;
      over_in = over_ff;
      if (ctl.clear) begin
         len_in  = '0;
         over_in = 1'b0;
      end else if (ctl.append) begin
         if (len_ff == LW'(MAX_MASKS)) begin
            over_in = 1'b1;
         end else begin
            len_in = len_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         over_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         over_ff <= over_in;
      end
   end

   // lane storage, written at the current length
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_MASKS; i++) begin
         if (ctl.append && len_ff == LW'(i)) begin
            lane_ff[i] <= app_id;
         end
      end
   end

   // found bits: one parallel compare per probed id
   always_comb begin
      found_in = found_ff;
      if (ctl.scan_start) begin
         found_in = '0;
      end else if (ctl.probe) begin
         for (int i = 0; i < MAX_MASKS; i++) begin
            found_in[i] = found_ff[i] | (lane_ff[i] == probe_id);
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
   end

   // lanes past the length do not count
   always_comb begin
      for (int i = 0; i < MAX_MASKS; i++) begin
         lane_ok[i] = found_ff[i] | (LW'(i) >= len_ff);
      end
   end

   assign all_found = &lane_ok;
   assign cur_len   = len_ff;
   assign cur_over  = over_ff;
   assign rd_id     = lane_ff[rd_idx];

endmodule

>>> hdl/mask_set_group_dedup_top.sv
// ----------------------------------------------------------------------------
// mask_set_group_dedup_top
// Clip group deduplication: collects the mask ids of a drawable, searches the
// stored groups in RAM for an equal set and returns or allocates a group.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_ch   | in  | valid/ready        | command, mask_id, last
//  rsp_ch   | out | valid/ready, reg'd | is_masked, group_index, new_group,
//           |     |                    | table_full, list_too_long, totals
//
//  Non-last ids and clear commands are taken in the idle state; a drawable without
//  masks goes straight to emit. A last id walks the stored groups one by one: a
//  group of another length is skipped after its length read, a group of equal
//  length is scanned with one list RAM read per stored id. A hit then goes to
//  emit; a miss passes the end-of-table check, copies the lanes, then emits.
//  Reset is synchronous and empties the group table; no clearing pass.
//  Requests are taken only while the sequencer is idle; a response waiting in
//  the output register holds the next result in emit, and no requests are taken then.
// ----------------------------------------------------------------------------
module mask_set_group_dedup_top #(
   parameter int MAX_GROUPS        = 64,
   parameter int MAX_MASKS         = 16,
   parameter int GROUPS_PER_BUFFER = 4
) (
   input  logic       clock,
   input  logic       reset,
   msgd_req_if.sink   req_ch,
   msgd_rsp_if.source rsp_ch
);

   localparam int LW      = $clog2(MAX_MASKS + 1);
   localparam int JW      = MAX_MASKS > 1 ? $clog2(MAX_MASKS) : 1;
   localparam int CW      = $clog2(MAX_GROUPS + 1);
   localparam int GW      = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
   localparam int NUM_BUF = (MAX_GROUPS + GROUPS_PER_BUFFER - 1) / GROUPS_PER_BUFFER;
   localparam int BW      = $clog2(NUM_BUF + 1);
   localparam int SW      = GROUPS_PER_BUFFER > 1 ? $clog2(GROUPS_PER_BUFFER) : 1;
   localparam int LIST_DEPTH = 1 << (GW + JW);
   localparam int LEN_DEPTH  = 1 << GW;

   msgd_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          g_ff, g_in;
   logic [LW-1:0]          j_ff, j_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [BW-1:0]          buf_ff, buf_in;
   logic [SW-1:0]          sub_ff, sub_in;
   msgd_pkg::res_type      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   msgd_pkg::res_type      rsp_res_ff, rsp_res_in;
   logic [msgd_pkg::GTOT_W-1:0] rsp_gtot_ff, rsp_gtot_in;
   logic [msgd_pkg::BTOT_W-1:0] rsp_btot_ff, rsp_btot_in;

   msgd_pkg::lane_ctl_type lane_ctl;
   logic [LW-1:0]          cur_len;
   logic                   cur_over;
   logic                   all_found;
   logic [msgd_pkg::ID_W-1:0] lane_rd_id;

   logic                   len_rd_en, len_wr_en;
   logic [GW-1:0]          len_rd_addr, len_wr_addr;
   logic [LW-1:0]          len_rd_data;
   logic                   list_rd_en, list_wr_en;
   logic [GW+JW-1:0]       list_rd_addr, list_wr_addr;
   logic [msgd_pkg::ID_W-1:0] list_rd_data;

   logic req_fire;
   logic out_free;

   assign req_ch.ready = (state_ff == msgd_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   // current list lanes
   msgd_lanes #(
      .MAX_MASKS (MAX_MASKS)
   ) u_lanes (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lane_ctl),
      .app_id    (req_ch.mask_id),
      .probe_id  (list_rd_data),
      .rd_idx    (j_ff[JW-1:0]),
      .cur_len   (cur_len),
      .cur_over  (cur_over),
      .all_found (all_found),
      .rd_id     (lane_rd_id)
   );

   // stored group lengths
   msgd_ram #(
      .WIDTH (LW),
      .DEPTH (LEN_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (cur_len),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   // stored group lists, one row of slots per group
   msgd_ram #(
      .WIDTH (msgd_pkg::ID_W),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (lane_rd_id),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   // sequencer: next state, RAM accesses and result
   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      buf_in       = buf_ff;
      sub_in       = sub_ff;
      res_in       = res_ff;
      lane_ctl     = '0;
      len_rd_en    = 1'b0;
      len_wr_en    = 1'b0;
      len_rd_addr  = g_ff[GW-1:0];
      len_wr_addr  = count_ff[GW-1:0];
      list_rd_en   = 1'b0;
      list_wr_en   = 1'b0;
      list_rd_addr = {g_ff[GW-1:0], j_ff[JW-1:0]};
      list_wr_addr = {count_ff[GW-1:0], j_ff[JW-1:0]};
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_gtot_in  = rsp_gtot_ff;
      rsp_btot_in  = rsp_btot_ff;

      unique case (state_ff)
         msgd_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.command)
                  msgd_pkg::CMD_MASK_ID: begin
                     lane_ctl.append = 1'b1;
                     if (req_ch.last) begin
                        g_in     = '0;
                        state_in = msgd_pkg::ST_SEARCH;
                     end
                  end
                  msgd_pkg::CMD_NO_MASKS: begin
                     lane_ctl.clear = 1'b1;
                     res_in         = '0;
                     state_in       = msgd_pkg::ST_EMIT;
                  end
                  msgd_pkg::CMD_CLEAR: begin
                     lane_ctl.clear = 1'b1;
                     count_in       = '0;
                     buf_in         = '0;
                     sub_in         = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // next group, or the end of the table
         msgd_pkg::ST_SEARCH: begin
            priority if (cur_over) begin
               res_in               = '0;
               res_in.list_too_long = 1'b1;
               state_in             = msgd_pkg::ST_EMIT;
            end else if (g_ff == count_ff) begin
               if (count_ff == CW'(MAX_GROUPS)) begin
                  res_in            = '0;
                  res_in.table_full = 1'b1;
                  state_in          = msgd_pkg::ST_EMIT;
               end else begin
                  j_in     = '0;
                  state_in = msgd_pkg::ST_COPY;
               end
            end else begin
               len_rd_en = 1'b1;
               state_in  = msgd_pkg::ST_LEN;
            end
         end

         // length must match before the ids are compared
         msgd_pkg::ST_LEN: begin
            if (len_rd_data != cur_len) begin
               g_in     = g_ff + CW'(1);
               state_in = msgd_pkg::ST_SEARCH;
            end else begin
               lane_ctl.scan_start = 1'b1;
               list_rd_en          = 1'b1;
               list_rd_addr        = {g_ff[GW-1:0], JW'(0)};
               j_in                = LW'(1);
               state_in            = msgd_pkg::ST_SCAN;
            end
         end

         // one stored id per cycle against all lanes
         msgd_pkg::ST_SCAN: begin
            lane_ctl.probe = 1'b1;
            if (j_ff < cur_len) begin
               list_rd_en = 1'b1;
               j_in       = j_ff + LW'(1);
            end else begin
               state_in = msgd_pkg::ST_CHECK;
            end
         end

         msgd_pkg::ST_CHECK: begin
            if (all_found) begin
               res_in             = '0;
               res_in.is_masked   = 1'b1;
               res_in.group_index = msgd_pkg::GIDX_W'(g_ff);
               state_in           = msgd_pkg::ST_EMIT;
            end else begin
               g_in     = g_ff + CW'(1);
               state_in = msgd_pkg::ST_SEARCH;
            end
         end

         // allocate: copy lanes into the next free row
         msgd_pkg::ST_COPY: begin
            list_wr_en = 1'b1;
            if (j_ff + LW'(1) == cur_len) begin
               len_wr_en          = 1'b1;
               count_in           = count_ff + CW'(1);
               if (sub_ff == '0) begin
                  buf_in = buf_ff + BW'(1);
               end
               sub_in             = (sub_ff == SW'(GROUPS_PER_BUFFER - 1)) ? '0
                                                                          : sub_ff + SW'(1);
               res_in             = '0;
               res_in.is_masked   = 1'b1;
               res_in.new_group   = 1'b1;
               res_in.group_index = msgd_pkg::GIDX_W'(count_ff);
               state_in           = msgd_pkg::ST_EMIT;
            end else begin
               j_in = j_ff + LW'(1);
            end
         end

         // hand the result to the output register
         msgd_pkg::ST_EMIT: begin
            lane_ctl.clear = 1'b1;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_gtot_in  = msgd_pkg::GTOT_W'(count_ff);
               rsp_btot_in  = msgd_pkg::BTOT_W'(buf_ff);
               state_in     = msgd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = msgd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msgd_pkg::ST_IDLE;
         count_ff     <= '0;
         buf_ff       <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         buf_ff       <= buf_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk counters
   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      j_ff        <= j_in;
      res_ff      <= res_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_gtot_ff <= rsp_gtot_in;
      rsp_btot_ff <= rsp_btot_in;
   end

   // response port
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.is_masked     = rsp_res_ff.is_masked;
   assign rsp_ch.group_index   = rsp_res_ff.group_index;
   assign rsp_ch.new_group     = rsp_res_ff.new_group;
   assign rsp_ch.table_full    = rsp_res_ff.table_full;
   assign rsp_ch.list_too_long = rsp_res_ff.list_too_long;
   assign rsp_ch.group_total   = rsp_gtot_ff;
   assign rsp_ch.buffer_total  = rsp_btot_ff;

`ifndef SYNTHESIS
   // group count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_GROUPS))
      else $error("group count beyond table size");

   // allocation only starts with a free row
   a_copy_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == msgd_pkg::ST_COPY |-> count_ff < CW'(MAX_GROUPS))
      else $error("group copy with full table");

   // a fresh group is always a masked, non-full result
   a_new_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.new_group |->
         rsp_res_ff.is_masked && !rsp_res_ff.table_full && !rsp_res_ff.list_too_long)
      else $error("inconsistent new group response");
`endif

endmodule

>>> tb/tb_mask_set_group_dedup_top.sv
// ----------------------------------------------------------------------------
// tb_mask_set_group_dedup_top
// Self-checking bench for the clip group dedup block. Drives mask id lists,
// unmasked drawables, table clears and unused commands over the request
// channel, predicts each group assignment in a scoreboard and checks every
// response field by field, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_mask_set_group_dedup_top;

   localparam int NUM_GROUPS     = 64;
   localparam int LIST_SLOTS     = 16;
   localparam int BUFFER_GROUPS  = 4;
   localparam int LIST_MAX       = LIST_SLOTS + 4;
   localparam int BANK_DEPTH     = 128;
   localparam int PHASE_ITEMS    = 425;
   localparam int HOLD_CYCLES    = 600;
   localparam int TAIL_CYCLES    = 100;
   localparam int LIMIT_CYCLES   = 20000000;

   // command code the block ignores
   localparam logic [msgd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic                        is_masked;
      logic [msgd_pkg::GIDX_W-1:0] group_index;
      logic                        new_group;
      logic                        table_full;
      logic                        list_too_long;
      logic [msgd_pkg::GTOT_W-1:0] group_total;
      logic [msgd_pkg::BTOT_W-1:0] buffer_total;
   } assignment_type;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of the group table, expected assignments in order
   // -------------------------------------------------------------------------
   class clip_group_board;
      logic [msgd_pkg::ID_W-1:0] cur_ids [LIST_SLOTS];
      int unsigned     cur_len;
      bit              cur_overlong;
      logic [msgd_pkg::ID_W-1:0] grp_ids [NUM_GROUPS][LIST_SLOTS];
      int unsigned     grp_len [NUM_GROUPS];
      int unsigned     grp_count;
      assignment_type  expected_groups [$];
      int              errors;

      function new();
         cur_len      = 0;
         cur_overlong = 0;
         grp_count    = 0;
         errors       = 0;
      endfunction

      function int pending();
         return expected_groups.size();
      endfunction

      function assignment_type make_assignment(bit masked, int unsigned idx, bit fresh,
                                               bit full, bit too_long);
         assignment_type a;
         int unsigned buffers;
         buffers         = (grp_count + BUFFER_GROUPS - 1) / BUFFER_GROUPS;
         a.is_masked     = masked;
         a.group_index   = masked ? idx[msgd_pkg::GIDX_W-1:0] : '0;
         a.new_group     = fresh;
         a.table_full    = full;
         a.list_too_long = too_long;
         a.group_total   = grp_count[msgd_pkg::GTOT_W-1:0];
         a.buffer_total  = buffers[msgd_pkg::BTOT_W-1:0];
         return a;
      endfunction

      // equal length and every current id present in the stored list
      function bit group_matches(int unsigned g);
         bit found;
         if (grp_len[g] != cur_len) return 0;
         for (int unsigned i = 0; i < cur_len; i++) begin
            found = 0;
            for (int unsigned j = 0; j < grp_len[g] && j < LIST_SLOTS; j++)
               if (grp_ids[g][j] == cur_ids[i]) found = 1;
            if (!found) return 0;
         end
         return 1;
      endfunction

      function assignment_type resolve_drawable();
         int unsigned g;
         if (cur_overlong) return make_assignment(0, 0, 0, 0, 1);
         for (int unsigned k = 0; k < grp_count && k < NUM_GROUPS; k++)
            if (group_matches(k)) return make_assignment(1, k, 0, 0, 0);
         if (grp_count >= NUM_GROUPS) return make_assignment(0, 0, 0, 1, 0);
         g = grp_count;
         for (int unsigned j = 0; j < cur_len && j < LIST_SLOTS; j++)
            grp_ids[g][j] = cur_ids[j];
         grp_len[g] = cur_len;
         grp_count  = g + 1;
         return make_assignment(1, g, 1, 0, 0);
      endfunction

      // update the model with one accepted request
      function void take_request(logic [msgd_pkg::CMD_W-1:0] cmd,
                                 logic [msgd_pkg::ID_W-1:0] id, logic lst);
         unique case (cmd)
            msgd_pkg::CMD_MASK_ID: begin
               if (cur_len < LIST_SLOTS) begin
                  cur_ids[cur_len] = id;
                  cur_len++;
               end else begin
                  cur_overlong = 1;
               end
               if (lst) begin
                  expected_groups.push_back(resolve_drawable());
                  cur_len      = 0;
                  cur_overlong = 0;
               end
            end
            msgd_pkg::CMD_NO_MASKS: begin
               cur_len      = 0;
               cur_overlong = 0;
               expected_groups.push_back(make_assignment(0, 0, 0, 0, 0));
            end
            msgd_pkg::CMD_CLEAR: begin
               grp_count    = 0;
               cur_len      = 0;
               cur_overlong = 0;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_assignment(assignment_type got);
         assignment_type want;
         if (expected_groups.size() == 0) begin
            $error("response with no drawable pending");
            errors++;
            return;
         end
         want = expected_groups.pop_front();
         compare_field("is_masked",     want.is_masked,     got.is_masked);
         compare_field("group_index",   want.group_index,   got.group_index);
         compare_field("new_group",     want.new_group,     got.new_group);
         compare_field("table_full",    want.table_full,    got.table_full);
         compare_field("list_too_long", want.list_too_long, got.list_too_long);
         compare_field("group_total",   want.group_total,   got.group_total);
         compare_field("buffer_total",  want.buffer_total,  got.buffer_total);
      endfunction

      function void check_drained();
         if (expected_groups.size() != 0) begin
            $error("%0d expected responses never arrived", expected_groups.size());
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   msgd_req_if req_ch ();
   msgd_rsp_if rsp_ch ();

   mask_set_group_dedup_top #(
      .MAX_GROUPS        (NUM_GROUPS),
      .MAX_MASKS         (LIST_SLOTS),
      .GROUPS_PER_BUFFER (BUFFER_GROUPS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clip_group_board board = new();

   int              send_idle_pct;
   int              recv_stall_pct;
   int              hold_order;
   int              hold_served;
   int              hold_left;
   int              items_sent;
   int              cycle_count = 0;

   // list under construction and a bank of earlier lists for reuse
   logic [msgd_pkg::ID_W-1:0] draw_ids [LIST_MAX];
   int              draw_len;
   logic [msgd_pkg::ID_W-1:0] bank_ids [BANK_DEPTH][LIST_SLOTS];
   int              bank_len [BANK_DEPTH];
   int              bank_fill;
   int              bank_wr;

   // clock and cycle count
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when ordered
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_order) begin
         hold_served = hold_order;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_assignment('{rsp_ch.is_masked, rsp_ch.group_index, rsp_ch.new_group,
                                  rsp_ch.table_full, rsp_ch.list_too_long,
                                  rsp_ch.group_total, rsp_ch.buffer_total});
   end

   // one request: optional idle gap, then hold until accepted
   task automatic send_request(input logic [msgd_pkg::CMD_W-1:0] cmd,
                               input logic [msgd_pkg::ID_W-1:0] id,
                               input logic lst);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.mask_id <= id;
      req_ch.last    <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.take_request(cmd, id, lst);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   task automatic send_draw_list();
      for (int i = 0; i < draw_len; i++)
         send_request(msgd_pkg::CMD_MASK_ID, draw_ids[i], i == draw_len - 1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [msgd_pkg::ID_W-1:0] fresh_id(bit narrow);
      return narrow ? msgd_pkg::ID_W'($urandom_range(7))
                    : msgd_pkg::ID_W'($urandom_range(1023));
   endfunction

   // one random drawable, mostly well formed lists, some noise
   task automatic random_drawable();
      int  r;
      int  k;
      int  a;
      int  b;
      bit  narrow;
      logic [msgd_pkg::ID_W-1:0] t;
      r      = $urandom_range(999);
      narrow = 1'($urandom_range(1));
      if (r < 5) begin
         send_request(msgd_pkg::CMD_CLEAR, fresh_id(0), 1'($urandom_range(1)));
      end else if (r < 65) begin
         send_request(msgd_pkg::CMD_NO_MASKS, fresh_id(0), 1'($urandom_range(1)));
      end else if (r < 85) begin
         send_request(CMD_UNUSED, fresh_id(0), 1'($urandom_range(1)));
      end else if (r < 115) begin
         // partial list abandoned by an unmasked drawable or a clear
         k = $urandom_range(1, 5);
         for (int i = 0; i < k; i++)
            send_request(msgd_pkg::CMD_MASK_ID, fresh_id(narrow), 1'b0);
         send_request($urandom_range(3) == 0 ? msgd_pkg::CMD_CLEAR : msgd_pkg::CMD_NO_MASKS,
                      fresh_id(0), 1'($urandom_range(1)));
      end else if (r < 145) begin
         // overlong list
         draw_len = $urandom_range(LIST_SLOTS + 1, LIST_MAX);
         for (int i = 0; i < draw_len; i++) draw_ids[i] = fresh_id(narrow);
         send_draw_list();
      end else if (r < 560 && bank_fill > 0) begin
         // earlier list in shuffled order, now and then with a duplicate
         k        = $urandom_range(bank_fill - 1);
         draw_len = bank_len[k];
         for (int i = 0; i < draw_len; i++) draw_ids[i] = bank_ids[k][i];
         for (int i = 0; i < draw_len; i++) begin
            a           = $urandom_range(draw_len - 1);
            t           = draw_ids[i];
            draw_ids[i] = draw_ids[a];
            draw_ids[a] = t;
         end
         if ($urandom_range(7) == 0) begin
            a           = $urandom_range(draw_len - 1);
            b           = $urandom_range(draw_len - 1);
            draw_ids[a] = draw_ids[b];
         end
         send_draw_list();
      end else begin
         // new list, short most of the time
         draw_len = ($urandom_range(9) == 0) ? $urandom_range(5, LIST_SLOTS)
                                             : $urandom_range(1, 4);
         for (int i = 0; i < draw_len; i++) begin
            draw_ids[i]          = fresh_id(narrow);
            bank_ids[bank_wr][i] = draw_ids[i];
         end
         bank_len[bank_wr] = draw_len;
         bank_wr           = (bank_wr + 1) % BANK_DEPTH;
         if (bank_fill < BANK_DEPTH) bank_fill++;
         send_draw_list();
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_drawable();
   endtask

   // main sequence
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = msgd_pkg::CMD_MASK_ID;
      req_ch.mask_id = '0;
      req_ch.last    = 1'b0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_order     = 0;
      hold_served    = 0;
      hold_left      = 0;
      items_sent     = 0;
      bank_fill      = 0;
      bank_wr        = 0;
      draw_len       = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, hits, permutations, duplicates, discards
      send_request(msgd_pkg::CMD_NO_MASKS, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd0, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd0, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd5, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd5, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd5, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd5, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd5, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b0);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd7, 1'b0);
      send_request(msgd_pkg::CMD_NO_MASKS, 10'd0, 1'b0);
      send_request(CMD_UNUSED, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'd7, 1'b1);
      send_request(msgd_pkg::CMD_CLEAR, 10'h3FF, 1'b1);
      send_request(msgd_pkg::CMD_MASK_ID, 10'h3FF, 1'b1);
      wait_drained();

      // no idling, with one long receiver hold-off to back up the input
      hold_order = hold_order + 1;
      run_phase(0, 0);
      wait_drained();
      run_phase(57, 0);
      wait_drained();
      run_phase(0, 57);
      wait_drained();
      run_phase(22, 22);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      board.check_drained();
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/msgd_pkg.sv
hdl/msgd_req_if.sv
hdl/msgd_rsp_if.sv
hdl/msgd_ram.sv
hdl/msgd_lanes.sv
hdl/mask_set_group_dedup_top.sv
tb/tb_mask_set_group_dedup_top.sv
